// ===== sv/sorted_table_count_occurrences_core_defines.svh =====
// Assertion macros used by the sorted table RTL.
`ifndef SORTED_TABLE_COUNT_OCCURRENCES_CORE_DEFINES_SVH
`define SORTED_TABLE_COUNT_OCCURRENCES_CORE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define STC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stc assertion failed");
// next-cycle implication
`define STC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stc assertion failed");
`else
`define STC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define STC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/stc_pkg.sv =====
// Shared types and codes for the sorted table block.
package stc_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } stc_action_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic load;
        logic query;
    } stc_cell_ctl_t;

endpackage

// ===== sv/stc_cell.sv =====
// One table cell: holds an entry, shifts on insert, flags compare on query.
module stc_cell
    import stc_pkg::*;
#(
    parameter int VALUE_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  stc_cell_ctl_t                ctl,
    input  logic signed [VALUE_BITS-1:0] key,
    input  logic                         occupied,
    input  logic                         prev_occupied,
    input  logic                         prev_gt,
    input  logic signed [VALUE_BITS-1:0] prev_value,
    output logic signed [VALUE_BITS-1:0] value,
    output logic                         gt,
    output logic                         lt_flag,
    output logic                         le_flag
);

    logic signed [VALUE_BITS-1:0] value_reg;
    logic signed [VALUE_BITS-1:0] value_next;
    logic                         lt_reg;
    logic                         lt_next;
    logic                         le_reg;
    logic                         le_next;

    assign gt = occupied && (value_reg > key);

    always_comb
    begin
        value_next = value_reg;
        if (ctl.load)
        begin
            if (prev_gt)
            begin
                value_next = prev_value;
            end
            else if (gt || (!occupied && prev_occupied))
            begin
                value_next = key;
            end
        end
    end

    assign lt_next = ctl.query ? (occupied && (value_reg < key))  : lt_reg;
    assign le_next = ctl.query ? (occupied && (value_reg <= key)) : le_reg;

    // entry storage has no reset; only occupied cells are ever compared
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            le_reg <= 1'b0;
        end
        else
        begin
            lt_reg <= lt_next;
            le_reg <= le_next;
        end
    end

    assign value   = value_reg;
    assign lt_flag = lt_reg;
    assign le_flag = le_reg;

endmodule

// ===== sv/stc_therm_enc.sv =====
// Thermometer-to-count encoder: number of leading ones from bit 0.
module stc_therm_enc
    import stc_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int CNT_W = 7
)
(
    input  logic [DEPTH-1:0] therm,
    output logic [CNT_W-1:0] count
);

    logic [DEPTH-1:0] therm_up;
    logic [DEPTH-1:0] boundary;

    assign therm_up = {1'b0, therm[DEPTH-1:1]};
    assign boundary = therm & ~therm_up;

    // boundary is one-hot or zero, so an OR of masked positions encodes it
    always_comb
    begin
        count = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (boundary[i])
            begin
                count = count | CNT_W'(i + 1);
            end
        end
    end

endmodule

// ===== sv/sorted_table_count_occurrences_core.sv =====
// Top level of the sorted table with occurrence count.
`include "sorted_table_count_occurrences_core_defines.svh"
// Sorted table core. Keeps up to TABLE_DEPTH signed entries in ascending
// order inside a row of insertion cells. An item is taken when start is high
// and busy is low. Clear (action 0) empties the table and load (action 1)
// inserts item_value after any equal entries; both finish in the accepting
// cycle, give no result, and the next item may follow in the very next
// cycle. A load into a full table is dropped, and action 3 is ignored.
// Query (action 2) goes as follows: at the accepting edge every cell
// registers a less-than and a less-or-equal flag against item_value; the
// next cycle turns both flag rows (thermometer codes, since the table is
// sorted) into counts, subtracts them and registers the answer. done then
// pulses for exactly one cycle with match_count, found, first_index and
// last_index; the receiver cannot stall it, so capture it on that cycle.
// busy is high only during the middle cycle of a query. A query passes
// through the cell compare stage followed by the encode/subtract stage.
// Indices are 0 when the value is not found. No clearing pass is needed
// after reset: occupancy comes from the stored count alone.
module sorted_table_count_occurrences_core
    import stc_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_BITS  = 16,
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
    localparam int IDX_W      = $clog2(TABLE_DEPTH)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   action,
    input  logic signed [VALUE_BITS-1:0] item_value,
    output logic                         done,
    output logic [CNT_W-1:0]             match_count,
    output logic                         found,
    output logic [IDX_W-1:0]             first_index,
    output logic [IDX_W-1:0]             last_index
);

    // control state
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // result registers
    logic [CNT_W-1:0] match_count_reg;
    logic [CNT_W-1:0] match_count_next;
    logic             found_reg;
    logic             found_next;
    logic [IDX_W-1:0] first_reg;
    logic [IDX_W-1:0] first_next;
    logic [IDX_W-1:0] last_reg;
    logic [IDX_W-1:0] last_next;

    logic          accept;
    logic          full;
    stc_action_t   act;
    stc_cell_ctl_t cell_ctl;

    logic signed [VALUE_BITS-1:0] cell_value [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]       cell_gt;
    logic [TABLE_DEPTH-1:0]       cell_occ;
    logic [TABLE_DEPTH-1:0]       lt_row;
    logic [TABLE_DEPTH-1:0]       le_row;

    logic [CNT_W-1:0] n_lt;
    logic [CNT_W-1:0] n_le;
    logic [CNT_W-1:0] n_diff;
    logic [CNT_W-1:0] n_le_m1;

    assign act    = stc_action_t'(action);
    assign accept = start && !busy_reg;
    assign full   = (count_reg == CNT_W'(TABLE_DEPTH));

    assign cell_ctl.load  = accept && (act == ACT_LOAD) && !full;
    assign cell_ctl.query = accept && (act == ACT_QUERY);

    // insertion chain: each cell looks only at its left neighbor
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic                         prev_occ;
        logic                         prev_gt;
        logic signed [VALUE_BITS-1:0] prev_val;

        assign cell_occ[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign prev_occ = 1'b1;
            assign prev_gt  = 1'b0;
            assign prev_val = cell_value[0];
        end
        else
        begin : g_body
            assign prev_occ = cell_occ[i-1];
            assign prev_gt  = cell_gt[i-1];
            assign prev_val = cell_value[i-1];
        end

        stc_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctl           (cell_ctl),
            .key           (item_value),
            .occupied      (cell_occ[i]),
            .prev_occupied (prev_occ),
            .prev_gt       (prev_gt),
            .prev_value    (prev_val),
            .value         (cell_value[i]),
            .gt            (cell_gt[i]),
            .lt_flag       (lt_row[i]),
            .le_flag       (le_row[i])
        );
    end

    // query encode stage: the flag rows are thermometer codes
    stc_therm_enc #(
        .DEPTH (TABLE_DEPTH),
        .CNT_W (CNT_W)
    ) u_enc_lt (
        .therm (lt_row),
        .count (n_lt)
    );

    stc_therm_enc #(
        .DEPTH (TABLE_DEPTH),
        .CNT_W (CNT_W)
    ) u_enc_le (
        .therm (le_row),
        .count (n_le)
    );

    assign n_diff  = n_le - n_lt;
    assign n_le_m1 = n_le - CNT_W'(1);

    always_comb
    begin
        count_next       = count_reg;
        busy_next        = 1'b0;
        done_next        = 1'b0;
        match_count_next = match_count_reg;
        found_next       = found_reg;
        first_next       = first_reg;
        last_next        = last_reg;

        if (accept)
        begin
            unique case (act)
                ACT_CLEAR: count_next = '0;
                ACT_LOAD:
                begin
                    if (!full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ACT_QUERY: busy_next = 1'b1;
                default:   ;
            endcase
        end

        if (busy_reg)
        begin
            done_next        = 1'b1;
            match_count_next = n_diff;
            found_next       = (n_diff != '0);
            first_next       = (n_diff != '0) ? n_lt[IDX_W-1:0] : '0;
            last_next        = (n_diff != '0) ? n_le_m1[IDX_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_count_reg <= match_count_next;
        found_reg       <= found_next;
        first_reg       <= first_next;
        last_reg        <= last_next;
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign match_count = match_count_reg;
    assign found       = found_reg;
    assign first_index = first_reg;
    assign last_index  = last_reg;

    `STC_ASSERT_NXT(a_query_sets_busy, clk, rst_n, cell_ctl.query, busy_reg)
    `STC_ASSERT_NXT(a_busy_then_done, clk, rst_n, busy_reg, done_reg && !busy_reg)
    `STC_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH))
    `STC_ASSERT_IMP(a_found_order, clk, rst_n, done_reg && found_reg, first_reg <= last_reg)
    `STC_ASSERT_IMP(a_miss_zero, clk, rst_n, done_reg && !found_reg,
        match_count_reg == '0 && first_reg == '0 && last_reg == '0)

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the sorted table occurrence counter.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stc_pkg::*;

    localparam int DEPTH        = 64;
    localparam int VBITS        = 16;
    localparam int IDLE_PCT     = 13;      // sender idles in about this many cycles of a hundred
    localparam int RANDOM_ITEMS = 1850;    // random items that actually touch the table
    localparam int DRAIN_CYCLES = 8;       // idle cycles after the last answer, to catch a stray one
    localparam int CYCLE_LIMIT  = 200000;  // many times the slowest legal run

    // One entry of the stimulus list. A hold entry stalls the sender until
    // every outstanding query answer has come back.
    typedef struct {
        logic               hold;
        stc_action_t        act;
        logic signed [15:0] val;
    } stim_t;

    // One query answer as the block reports it.
    typedef struct {
        logic [6:0] count;
        logic       hit;
        logic [5:0] first;
        logic [5:0] last;
    } answer_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    stc_action_t        action;
    logic signed [15:0] item_value;
    logic               done;
    logic [6:0]         match_count;
    logic               found;
    logic [5:0]         first_index;
    logic [5:0]         last_index;

    stim_t   stim_q[$];       // items waiting to be driven
    answer_t answer_q[$];     // query answers owed by the block, oldest first

    // Shadow copy of the table: ascending over the first shadow_fill entries.
    logic signed [15:0] shadow_table [DEPTH];
    int                 shadow_fill;

    int total_items;
    int accepted_items;
    int error_count;
    int cycle_count;
    int gen_fill;             // table fill as the generator sees it
    int counted;              // random items that reach the table

    sorted_table_count_occurrences_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .item_value  (item_value),
        .done        (done),
        .match_count (match_count),
        .found       (found),
        .first_index (first_index),
        .last_index  (last_index)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow table: apply one accepted item and queue the answer it owes.
    // Loads go after any equal entries; loads into a full table and the
    // unused action code change nothing.
    // ------------------------------------------------------------------
    task automatic apply_to_shadow(input stc_action_t act, input logic signed [15:0] v);
        int      pos;
        answer_t ans;
        case (act)
            ACT_CLEAR:
            begin
                shadow_fill = 0;
            end
            ACT_LOAD:
            begin
                if (shadow_fill < DEPTH)
                begin
                    pos = shadow_fill;
                    while (pos > 0 && shadow_table[pos-1] > v)
                    begin
                        shadow_table[pos] = shadow_table[pos-1];
                        pos--;
                    end
                    shadow_table[pos] = v;
                    shadow_fill++;
                end
            end
            ACT_QUERY:
            begin
                ans = '{count: '0, hit: 1'b0, first: '0, last: '0};
                for (pos = 0; pos < shadow_fill; pos++)
                begin
                    if (shadow_table[pos] == v)
                    begin
                        if (!ans.hit)
                            ans.first = pos[5:0];
                        ans.last = pos[5:0];
                        ans.hit = 1'b1;
                        ans.count++;
                    end
                end
                answer_q.push_back(ans);
            end
            default:
            begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus list helpers
    // ------------------------------------------------------------------
    task automatic add_item(input stc_action_t act, input logic signed [15:0] v);
        stim_q.push_back('{hold: 1'b0, act: act, val: v});
        total_items++;
        // ignored items do not count toward the random budget
        if (act == ACT_CLEAR)
        begin
            gen_fill = 0;
            counted++;
        end
        else if (act == ACT_LOAD)
        begin
            if (gen_fill < DEPTH)
            begin
                gen_fill++;
                counted++;
            end
        end
        else if (act == ACT_QUERY)
            counted++;
    endtask

    task automatic add_hold();
        stim_q.push_back('{hold: 1'b1, act: ACT_NONE, val: '0});
    endtask

    // mostly plain random values, now and then an extreme, zero or minus one
    function automatic logic signed [15:0] pick_pool_value();
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(7) == 0)
        begin
            case (r[1:0])
                2'd0: return 16'sh8000;
                2'd1: return 16'sh7fff;
                2'd2: return 16'sh0000;
                default: return 16'shffff;
            endcase
        end
        return r[15:0];
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: directed opening, then random fill-and-search sequences
    // ------------------------------------------------------------------
    initial
    begin : build_stimulus
        logic signed [15:0] pool [6];
        int                 pool_size;
        int                 n_loads;
        int                 n_queries;
        int                 r;
        int                 k;

        total_items = 0;
        gen_fill    = 0;
        counted     = 0;

        // empty table answers not found, extremes of the value range
        add_item(ACT_QUERY, 16'sh0000);
        add_item(ACT_QUERY, 16'sh8000);
        add_item(ACT_QUERY, 16'sh7fff);
        // loads out of order with a duplicate pair
        add_item(ACT_LOAD,  16'sh7fff);
        add_item(ACT_LOAD,  16'sh8000);
        add_item(ACT_LOAD,  16'sh0000);
        add_item(ACT_LOAD,  16'sh0000);
        add_item(ACT_LOAD,  16'shffff);
        add_item(ACT_QUERY, 16'sh0000);   // duplicates in the middle
        add_item(ACT_QUERY, 16'sh8000);   // lowest entry
        add_item(ACT_QUERY, 16'sh7fff);   // highest entry
        add_item(ACT_QUERY, 16'shffff);
        add_item(ACT_QUERY, 16'sh0001);   // not found between entries
        add_item(ACT_NONE,  16'sh0000);   // unused code must change nothing
        add_item(ACT_QUERY, 16'sh0000);
        add_item(ACT_CLEAR, 16'sh5555);
        add_item(ACT_QUERY, 16'sh0000);   // table empty again
        add_item(ACT_LOAD,  16'sh0005);
        add_item(ACT_NONE,  16'shffff);
        add_item(ACT_QUERY, 16'sh0005);
        add_item(ACT_QUERY, 16'shfffb);
        add_hold();

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if ($urandom_range(9) == 0)
                add_hold();
            // now and then keep the old contents so the table runs full
            if ($urandom_range(7) != 0)
                add_item(ACT_CLEAR, 16'($urandom));

            r = $urandom_range(99);
            if (r < 10)
            begin
                // long fill, at times past capacity, with few distinct values
                n_loads   = $urandom_range(60, 72);
                pool_size = $urandom_range(1, 2);
            end
            else
            begin
                n_loads   = $urandom_range(1, 24);
                pool_size = $urandom_range(1, 6);
            end
            for (k = 0; k < pool_size; k++)
                pool[k] = pick_pool_value();

            for (k = 0; k < n_loads; k++)
            begin
                if ($urandom_range(99) < 80)
                    add_item(ACT_LOAD, pool[$urandom_range(pool_size - 1)]);
                else
                    add_item(ACT_LOAD, 16'($urandom));
                // a search now and then while the table is still filling
                if ($urandom_range(99) < 15)
                    add_item(ACT_QUERY, pool[$urandom_range(pool_size - 1)]);
                if ($urandom_range(99) < 4)
                    add_item(ACT_NONE, 16'($urandom));
            end

            n_queries = $urandom_range(3, 10);
            for (k = 0; k < n_queries; k++)
            begin
                if ($urandom_range(99) < 75)
                    add_item(ACT_QUERY, pool[$urandom_range(pool_size - 1)]);
                else
                    add_item(ACT_QUERY, 16'($urandom));
                if ($urandom_range(99) < 4)
                    add_item(ACT_NONE, 16'($urandom));
            end
        end
    end

    // ------------------------------------------------------------------
    // Reset: asserted once at the start
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver. An item is taken at an edge where start is high and busy is
    // low; the shadow table is updated at that same edge. While a query is
    // in its middle cycle busy holds the next item off and a raised start stays up.
    // Idling is switched off over a stretch of the run.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        stim_t nxt;
        logic  idle_on;
        if (!rst_n)
        begin
            start      <= 1'b0;
            action     <= ACT_CLEAR;
            item_value <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_to_shadow(action, item_value);
                accepted_items++;
            end
            idle_on = !(accepted_items >= 700 && accepted_items < 1100);
            if (!(start && busy))
            begin
                if (stim_q.size() == 0)
                    start <= 1'b0;
                else if (stim_q[0].hold)
                begin
                    // pause until the block owes nothing
                    start <= 1'b0;
                    if (answer_q.size() == 0)
                        void'(stim_q.pop_front());
                end
                else if (idle_on && $urandom_range(99) < IDLE_PCT)
                begin
                    // idle cycle: junk on the fields must be ignored
                    start      <= 1'b0;
                    action     <= stc_action_t'($urandom_range(3));
                    item_value <= 16'($urandom);
                end
                else
                begin
                    nxt = stim_q.pop_front();
                    start      <= 1'b1;
                    action     <= nxt.act;
                    item_value <= nxt.val;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: done marks one answer for one cycle, taken at the edge that
    // ends it. Every answer must match the oldest one owed.
    // ------------------------------------------------------------------
    task automatic log_failure(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : check_answers
        answer_t want;
        if (rst_n && done)
        begin
            if (answer_q.size() == 0)
                log_failure($sformatf({"answer with no query pending:",
                                       " count=%0d found=%0b first=%0d last=%0d"},
                                      match_count, found, first_index, last_index));
            else
            begin
                want = answer_q.pop_front();
                if (match_count !== want.count || found !== want.hit ||
                    first_index !== want.first || last_index !== want.last)
                    log_failure($sformatf({"mismatch: expected count=%0d found=%0b",
                                           " first=%0d last=%0d,",
                                           " got count=%0d found=%0b first=%0d last=%0d"},
                                          want.count, want.hit, want.first, want.last,
                                          match_count, found, first_index, last_index));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // End of run: everything sent and answered, then a short drain so a
    // stray answer still gets caught.
    // ------------------------------------------------------------------
    initial
    begin : finish_run
        accepted_items = 0;
        error_count    = 0;
        cycle_count    = 0;
        shadow_fill    = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        wait (stim_q.size() == 0 && accepted_items == total_items && answer_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && answer_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
